// ----- rtl/limit_order_matcher_assert.svh -----
// ----------------------------------------------------------------------------
// limit order matcher assertion macros
// Concurrent checks on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef LIMIT_ORDER_MATCHER_ASSERT_SVH
`define LIMIT_ORDER_MATCHER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define LOM_ASSERT_IMP(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (b)) \
    else $error(msg);
`define LOM_ASSERT_NXT(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (b)) \
    else $error(msg);
`else
`define LOM_ASSERT_IMP(lbl, a, b, msg)
`define LOM_ASSERT_NXT(lbl, a, b, msg)
`endif
`endif

// ----- rtl/lom_pkg.sv -----
// ----------------------------------------------------------------------------
// lom_pkg
// Shared types and constants of the limit order matcher.
// ----------------------------------------------------------------------------
package lom_pkg;

  localparam int unsigned PriceLevelsDef = 1024;
  localparam int unsigned OrderSlotsDef  = 1024;
  localparam int unsigned MaxFillsDef    = 63;

  localparam int unsigned IdW   = 32;
  localparam int unsigned TickW = 10;
  localparam int unsigned QtyW  = 24;
  localparam int unsigned KindW = 3;

  typedef enum logic {
    CMD_ADD    = 1'b0,
    CMD_CANCEL = 1'b1
  } lom_cmd_e;

  typedef enum logic [KindW-1:0] {
    KIND_FILL      = 3'd0,
    KIND_RESTED    = 3'd1,
    KIND_DONE      = 3'd2,
    KIND_CANCELLED = 3'd3,
    KIND_UNKNOWN   = 3'd4,
    KIND_FULL      = 3'd5,
    KIND_CAP       = 3'd6
  } lom_kind_e;

  typedef struct packed {
    logic             cmd;
    logic [IdW-1:0]   order_id;
    logic             side;
    logic [TickW-1:0] price_tick;
    logic [QtyW-1:0]  quantity;
  } lom_item_t;

  typedef struct packed {
    logic [KindW-1:0] result_kind;
    logic [IdW-1:0]   buy_id;
    logic [IdW-1:0]   sell_id;
    logic [TickW-1:0] fill_price;
    logic [QtyW-1:0]  fill_qty;
    logic             last;
  } lom_result_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_T_STEP,
    OP_HEAD_SEL,
    OP_HEAD_LATCH,
    OP_FILL,
    OP_SCAN_INIT,
    OP_SCAN_STEP,
    OP_REST_SEL,
    OP_REST,
    OP_CAN_SEL,
    OP_CANCEL,
    OP_MISS,
    OP_DONE,
    OP_CAP,
    OP_FULL
  } lom_op_e;

  typedef struct packed {
    lom_op_e op;
    logic    slot_scan;
    logic    lvl_srch;
  } lom_ctl_t;

  typedef struct packed {
    logic clr_done;
    logic is_cancel;
    logic qty_zero;
    logic occ_hit;
    logic t_at_limit;
    logic cap_hit;
    logic rem_cleared;
    logic slot_free;
    logic id_hit;
    logic scan_last;
  } lom_stat_t;

endpackage

// ----- rtl/lom_datapath.sv -----
// ----------------------------------------------------------------------------
// lom_datapath
// Order book memories, item registers and the result register.
// ----------------------------------------------------------------------------
module lom_datapath import lom_pkg::*; #(
  parameter int unsigned PriceLevels = PriceLevelsDef,
  parameter int unsigned OrderSlots  = OrderSlotsDef,
  parameter int unsigned MaxFills    = MaxFillsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  lom_ctl_t    ctl_i,
  output lom_stat_t   stat_o,
  input  lom_item_t   item_i,
  output lom_result_t result_o,
  output logic        result_valid_o
);

  `include "limit_order_matcher_assert.svh"

  localparam int unsigned Levels = 2 * PriceLevels;
  localparam int unsigned TW = $clog2(PriceLevels);
  localparam int unsigned LW = $clog2(Levels);
  localparam int unsigned SW = $clog2(OrderSlots);
  localparam int unsigned NW = $clog2(MaxFills + 1);
  localparam int unsigned ClrLen = (Levels > OrderSlots) ? Levels : OrderSlots;
  localparam int unsigned CW = $clog2(ClrLen);

  function automatic logic [LW-1:0] lvl_of(input logic sell, input logic [TW-1:0] t);
    logic [LW-1:0] base;
    base = sell ? LW'(PriceLevels) : '0;
    return base + LW'(t);
  endfunction

  // slot store
  logic [IdW-1:0]   id_mem   [OrderSlots];
  logic [QtyW-1:0]  amt_mem  [OrderSlots];
  logic [TickW-1:0] tick_mem [OrderSlots];
  logic             sell_mem [OrderSlots];
  logic [SW-1:0]    next_mem [OrderSlots];
  logic [SW-1:0]    prev_mem [OrderSlots];
  logic             use_mem  [OrderSlots];
  // level store
  logic [SW-1:0]    head_mem [Levels];
  logic [SW-1:0]    tail_mem [Levels];
  logic             occ_mem  [Levels];

  logic [IdW-1:0]   id_rq;
  logic [QtyW-1:0]  amt_rq;
  logic [TickW-1:0] tick_rq;
  logic             sell_rq;
  logic [SW-1:0]    next_rq, prev_rq, head_rq, tail_rq;
  logic             use_rq, occ_rq;

  logic             cmd_q, side_q;
  logic [IdW-1:0]   id_q;
  logic [TickW-1:0] tick_q;
  logic [QtyW-1:0]  rem_q;
  logic [NW-1:0]    n_q;
  logic [TW-1:0]    t_q;
  logic [SW-1:0]    scan_q, s_q;
  logic [LW-1:0]    lv_q;
  logic [CW-1:0]    clr_q;
  lom_result_t      res_q, res_d;
  logic             res_valid_q, emit;

  logic [SW-1:0]    slot_ra;
  logic [LW-1:0]    lvl_ra;
  logic [TW-1:0]    lim, t_start, item_t_start;
  logic [TickW-1:0] tick_sat;
  logic [QtyW-1:0]  tq;
  logic             hm, tm, drop;

  logic             slot_we, use_we, use_wd, next_we, prev_we;
  logic [SW-1:0]    use_wa, next_wa, next_wd, prev_wa, prev_wd;
  logic [QtyW-1:0]  amt_wd;
  logic             amt_we;
  logic             occ_we, occ_wd, head_we, tail_we;
  logic [LW-1:0]    occ_wa;
  logic [SW-1:0]    head_wd, tail_wd;

  assign lim          = TW'(tick_q);
  assign t_start      = side_q ? TW'(PriceLevels - 1) : '0;
  assign item_t_start = item_i.side ? TW'(PriceLevels - 1) : '0;
  assign tick_sat     = ({22'd0, item_i.price_tick} >= 32'(PriceLevels)) ?
                        TickW'(PriceLevels - 1) : item_i.price_tick;
  assign slot_ra      = ctl_i.slot_scan ? scan_q : s_q;
  assign lvl_ra       = ctl_i.lvl_srch ? lvl_of(!side_q, t_q) : lv_q;
  assign tq           = (rem_q < amt_rq) ? rem_q : amt_rq;
  assign hm           = head_rq == s_q;
  assign tm           = tail_rq == s_q;
  assign drop         = (ctl_i.op == OP_FILL && amt_rq <= rem_q) || ctl_i.op == OP_CANCEL;

  assign stat_o.clr_done    = clr_q == CW'(ClrLen - 1);
  assign stat_o.is_cancel   = cmd_q == CMD_CANCEL;
  assign stat_o.qty_zero    = rem_q == '0;
  assign stat_o.occ_hit     = occ_rq;
  assign stat_o.t_at_limit  = t_q == lim;
  assign stat_o.cap_hit     = n_q == NW'(MaxFills);
  assign stat_o.rem_cleared = rem_q <= amt_rq;
  assign stat_o.slot_free   = !use_rq;
  assign stat_o.id_hit      = use_rq && (id_rq == id_q);
  assign stat_o.scan_last   = scan_q == SW'(OrderSlots - 1);

  // write ports of the stores
  always_comb begin
    slot_we = 1'b0;
    amt_we  = 1'b0;
    amt_wd  = rem_q;
    use_we  = 1'b0;
    use_wa  = s_q;
    use_wd  = 1'b0;
    next_we = 1'b0;
    next_wa = prev_rq;
    next_wd = next_rq;
    prev_we = 1'b0;
    prev_wa = next_rq;
    prev_wd = prev_rq;
    occ_we  = 1'b0;
    occ_wa  = lv_q;
    occ_wd  = 1'b0;
    head_we = 1'b0;
    head_wd = next_rq;
    tail_we = 1'b0;
    tail_wd = prev_rq;
    if (drop) begin
      use_we = 1'b1;
      if (hm && tm) begin
        occ_we = 1'b1;
      end else if (hm) begin
        head_we = 1'b1;
      end else if (tm) begin
        tail_we = 1'b1;
      end else begin
        next_we = 1'b1;
        prev_we = 1'b1;
      end
    end
    case (ctl_i.op)
      OP_CLEAR: begin
        use_we = {1'b0, clr_q} < (CW+1)'(OrderSlots);
        use_wa = clr_q[SW-1:0];
        occ_we = {1'b0, clr_q} < (CW+1)'(Levels);
        occ_wa = clr_q[LW-1:0];
      end
      OP_FILL: begin
        amt_we = 1'b1;
        amt_wd = amt_rq - tq;
      end
      OP_REST: begin
        slot_we = 1'b1;
        amt_we  = 1'b1;
        use_we  = 1'b1;
        use_wd  = 1'b1;
        tail_we = 1'b1;
        tail_wd = s_q;
        if (occ_rq) begin
          prev_we = 1'b1;
          prev_wa = s_q;
          prev_wd = tail_rq;
          next_we = 1'b1;
          next_wa = tail_rq;
          next_wd = s_q;
        end else begin
          occ_we  = 1'b1;
          occ_wd  = 1'b1;
          head_we = 1'b1;
          head_wd = s_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      id_mem[s_q]   <= id_q;
      tick_mem[s_q] <= tick_q;
      sell_mem[s_q] <= side_q;
    end
    if (amt_we)  amt_mem[s_q]      <= amt_wd;
    if (use_we)  use_mem[use_wa]   <= use_wd;
    if (next_we) next_mem[next_wa] <= next_wd;
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (occ_we)  occ_mem[occ_wa]   <= occ_wd;
    if (head_we) head_mem[lv_q]    <= head_wd;
    if (tail_we) tail_mem[lv_q]    <= tail_wd;
    id_rq   <= id_mem[slot_ra];
    amt_rq  <= amt_mem[slot_ra];
    tick_rq <= tick_mem[slot_ra];
    sell_rq <= sell_mem[slot_ra];
    next_rq <= next_mem[slot_ra];
    prev_rq <= prev_mem[slot_ra];
    use_rq  <= use_mem[slot_ra];
    head_rq <= head_mem[lvl_ra];
    tail_rq <= tail_mem[lvl_ra];
    occ_rq  <= occ_mem[lvl_ra];
  end

  // result of the current op
  always_comb begin
    emit              = 1'b1;
    res_d.result_kind = KIND_DONE;
    res_d.buy_id      = id_q;
    res_d.sell_id     = '0;
    res_d.fill_price  = tick_q;
    res_d.fill_qty    = '0;
    res_d.last        = 1'b1;
    case (ctl_i.op)
      OP_FILL: begin
        res_d.result_kind = KIND_FILL;
        res_d.buy_id      = side_q ? id_rq : id_q;
        res_d.sell_id     = side_q ? id_q : id_rq;
        res_d.fill_price  = tick_rq;
        res_d.fill_qty    = tq;
        res_d.last        = 1'b0;
      end
      OP_REST: begin
        res_d.result_kind = KIND_RESTED;
        res_d.fill_qty    = rem_q;
      end
      OP_CANCEL: begin
        res_d.result_kind = KIND_CANCELLED;
        res_d.fill_price  = tick_rq;
        res_d.fill_qty    = amt_rq;
      end
      OP_MISS: begin
        res_d.result_kind = KIND_UNKNOWN;
        res_d.fill_price  = '0;
      end
      OP_DONE: ;
      OP_CAP: begin
        res_d.result_kind = KIND_CAP;
        res_d.fill_qty    = rem_q;
      end
      OP_FULL: begin
        res_d.result_kind = KIND_FULL;
        res_d.fill_qty    = rem_q;
      end
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      clr_q       <= '0;
    end else begin
      res_valid_q <= emit;
      if (ctl_i.op == OP_CLEAR) clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) res_q <= res_d;
    case (ctl_i.op)
      OP_LOAD: begin
        cmd_q  <= item_i.cmd;
        id_q   <= item_i.order_id;
        side_q <= item_i.side;
        tick_q <= tick_sat;
        rem_q  <= item_i.quantity;
        n_q    <= '0;
        t_q    <= item_t_start;
        scan_q <= '0;
      end
      OP_T_STEP:     t_q <= side_q ? t_q - 1'b1 : t_q + 1'b1;
      OP_HEAD_SEL:   lv_q <= lvl_of(!side_q, t_q);
      OP_HEAD_LATCH: s_q <= head_rq;
      OP_FILL: begin
        rem_q <= rem_q - tq;
        n_q   <= n_q + 1'b1;
        t_q   <= t_start;
      end
      OP_SCAN_INIT:  scan_q <= '0;
      OP_SCAN_STEP:  scan_q <= scan_q + 1'b1;
      OP_REST_SEL: begin
        s_q  <= scan_q;
        lv_q <= lvl_of(side_q, lim);
      end
      OP_CAN_SEL: begin
        s_q  <= scan_q;
        lv_q <= lvl_of(sell_rq, TW'(tick_rq));
      end
      default: ;
    endcase
  end

  assign result_o       = res_q;
  assign result_valid_o = res_valid_q;

  `LOM_ASSERT_IMP(a_fill_below_cap, ctl_i.op == OP_FILL, n_q < NW'(MaxFills), "fill past cap")
  `LOM_ASSERT_NXT(a_gap_after_last, res_valid_q && res_q.last, !res_valid_q, "result after last")
  `LOM_ASSERT_IMP(a_rest_free_slot, ctl_i.op == OP_REST, !use_rq, "rest into used slot")

endmodule

// ----- rtl/lom_ctrl.sv -----
// ----------------------------------------------------------------------------
// lom_ctrl
// Sequencer: clear pass, level search, fills, slot scans, rest and cancel.
// ----------------------------------------------------------------------------
module lom_ctrl import lom_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  lom_stat_t stat_i,
  output lom_ctl_t  ctl_o
);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_DISP, S_XRD, S_XCHK, S_HRD, S_HCHK, S_SRD, S_FILL, S_FIN,
    S_FRD, S_FCHK, S_RRD, S_REST, S_CRD, S_CCHK, S_CLRD, S_CAN
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;

  always_comb begin
    state_d = state_q;
    ctl_o   = '{op: OP_NONE, slot_scan: 1'b0, lvl_srch: 1'b0};
    case (state_q)
      S_CLR: begin
        ctl_o.op = OP_CLEAR;
        if (stat_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          ctl_o.op = OP_LOAD;
          state_d  = S_DISP;
        end
      end
      S_DISP: begin
        ctl_o.slot_scan = 1'b1;
        if (stat_i.is_cancel) begin
          state_d = S_CRD;
        end else if (stat_i.qty_zero) begin
          ctl_o.op = OP_DONE;
          state_d  = S_IDLE;
        end else begin
          state_d = S_XRD;
        end
      end
      S_XRD: begin
        ctl_o.lvl_srch = 1'b1;
        state_d        = S_XCHK;
      end
      S_XCHK: begin
        if (stat_i.occ_hit) begin
          if (stat_i.cap_hit) begin
            ctl_o.op = OP_CAP;
            state_d  = S_IDLE;
          end else begin
            ctl_o.op = OP_HEAD_SEL;
            state_d  = S_HRD;
          end
        end else if (stat_i.t_at_limit) begin
          ctl_o.op = OP_SCAN_INIT;
          state_d  = S_FRD;
        end else begin
          ctl_o.op = OP_T_STEP;
          state_d  = S_XRD;
        end
      end
      S_HRD: state_d = S_HCHK;
      S_HCHK: begin
        ctl_o.op = OP_HEAD_LATCH;
        state_d  = S_SRD;
      end
      S_SRD: state_d = S_FILL;
      S_FILL: begin
        ctl_o.op = OP_FILL;
        state_d  = stat_i.rem_cleared ? S_FIN : S_XRD;
      end
      S_FIN: begin
        ctl_o.op = OP_DONE;
        state_d  = S_IDLE;
      end
      S_FRD: begin
        ctl_o.slot_scan = 1'b1;
        state_d         = S_FCHK;
      end
      S_FCHK: begin
        if (stat_i.slot_free) begin
          ctl_o.op = OP_REST_SEL;
          state_d  = S_RRD;
        end else if (stat_i.scan_last) begin
          ctl_o.op = OP_FULL;
          state_d  = S_IDLE;
        end else begin
          ctl_o.op = OP_SCAN_STEP;
          state_d  = S_FRD;
        end
      end
      S_RRD: state_d = S_REST;
      S_REST: begin
        ctl_o.op = OP_REST;
        state_d  = S_IDLE;
      end
      S_CRD: begin
        ctl_o.slot_scan = 1'b1;
        state_d         = S_CCHK;
      end
      S_CCHK: begin
        if (stat_i.id_hit) begin
          ctl_o.op = OP_CAN_SEL;
          state_d  = S_CLRD;
        end else if (stat_i.scan_last) begin
          ctl_o.op = OP_MISS;
          state_d  = S_IDLE;
        end else begin
          ctl_o.op = OP_SCAN_STEP;
          state_d  = S_CRD;
        end
      end
      S_CLRD: state_d = S_CAN;
      S_CAN: begin
        ctl_o.op = OP_CANCEL;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      busy_q  <= 1'b1;
    end else begin
      state_q <= state_d;
      busy_q  <= state_d != S_IDLE;
    end
  end

  assign busy = busy_q;

endmodule

// ----- rtl/limit_order_matcher.sv -----
// ----------------------------------------------------------------------------
// limit_order_matcher
// Single-instrument limit order book with price-time priority matching.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                    payload
//  item      in         start high while busy low    item_i (lom_item_t)
//  result    out        result_valid_o, one cycle    result_o (lom_result_t)
//
// an add is dispatched, each best-price search checks price levels in turn, each fill
// reads its level head then its slot, a free-slot scan checks slots in turn, then it rests
// a cancel is dispatched, slots are scanned in turn for its id, and a hit is read and cancelled
// all tables are memories with registered reads, at most one read and one write per step
// after reset a clearing pass over max(2*PRICE_LEVELS, ORDER_SLOTS) entries holds busy
// results cannot be held off; each is shown for exactly one cycle
module limit_order_matcher import lom_pkg::*; #(
  parameter int unsigned PriceLevels = PriceLevelsDef,
  parameter int unsigned OrderSlots  = OrderSlotsDef,
  parameter int unsigned MaxFills    = MaxFillsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  lom_item_t   item_i,
  output lom_result_t result_o,
  output logic        result_valid_o
);

  lom_ctl_t  ctl;
  lom_stat_t stat;

  lom_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .ctl_o  (ctl)
  );

  lom_datapath #(
    .PriceLevels (PriceLevels),
    .OrderSlots  (OrderSlots),
    .MaxFills    (MaxFills)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .stat_o         (stat),
    .item_i         (item_i),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

endmodule
